[hdl/median_filter_window_top_macros.svh]
// Assertion macros for the median filter window block.
// Used by median_filter_window_top; needs nothing else.
`ifndef MEDIAN_FILTER_WINDOW_TOP_MACROS_SVH
`define MEDIAN_FILTER_WINDOW_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define MFW_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define MFW_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hdl/mfw_pkg.sv]
// Shared constants, types and helpers for the median filter window block.
// No dependencies; every other file but the macros header uses it.
`default_nettype none

package mfw_pkg;

   localparam int MAX_WIDTH   = 1024;
   localparam int MAX_HEIGHT  = 1024;
   localparam int WINDOW      = 3;
   localparam int HALF_WIN    = WINDOW / 2;
   localparam int WIN_AREA    = WINDOW * WINDOW;
   localparam int MEDIAN_RANK = WIN_AREA / 2;
   localparam int LINES       = WINDOW - 1;
   localparam int SIZE_RESET  = 1024;

   localparam int PIX_W       = 8;
   localparam int CFG_W       = 11;
   localparam int COORD_W     = 10;
   localparam int COL_W       = $clog2(MAX_WIDTH);
   localparam int ROW_W       = $clog2(MAX_HEIGHT);
   localparam int WID_W       = $clog2(MAX_WIDTH + 1);
   localparam int HGT_W       = $clog2(MAX_HEIGHT + 1);
   localparam int RANK_W      = $clog2(WIN_AREA);
   localparam int CSR_INDEX_W = 1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_IMAGE_WIDTH,
      CSR_IMAGE_HEIGHT
   } csr_index_type;

   typedef logic [PIX_W-1:0]          pixel_type;
   typedef logic [COL_W-1:0]          col_type;
   typedef pixel_type [LINES-1:0]     line_word_type;
   typedef pixel_type [WIN_AREA-1:0]  window_type;

   // Position details that travel with a pixel down the pipeline.
   typedef struct packed {
      logic               has_result;
      logic               frame_last;
      logic [COORD_W-1:0] centre_row;
      logic [COORD_W-1:0] centre_col;
   } pos_info_type;

   // Saturate a programmed size into the range WINDOW .. maxv.
   function automatic logic [31:0] clamp_size(input logic [CFG_W-1:0] v,
                                              input logic [31:0] maxv);
      logic [31:0] ext;
      logic [31:0] res;
      ext = 32'(v);
      if (ext > maxv) begin
         res = maxv;
      end else if (ext < 32'(WINDOW)) begin
         res = 32'(WINDOW);
      end else begin
         res = ext;
      end
      return res;
   endfunction

endpackage

`default_nettype wire

[hdl/mfw_if.sv]
// Valid/ready channel interfaces for pixels in and medians out.
// Depends on mfw_pkg.
`default_nettype none

interface mfw_req_if import mfw_pkg::*; ();
   logic      valid;
   logic      ready;
   pixel_type pixel;

   modport source (output valid, output pixel, input ready);
   modport sink   (input valid, input pixel, output ready);
endinterface

interface mfw_rsp_if import mfw_pkg::*; ();
   logic               valid;
   logic               ready;
   pixel_type          median_value;
   logic [COORD_W-1:0] centre_row;
   logic [COORD_W-1:0] centre_col;
   logic               frame_last;

   modport source (output valid, output median_value, output centre_row,
                   output centre_col, output frame_last, input ready);
   modport sink   (input valid, input median_value, input centre_row,
                   input centre_col, input frame_last, output ready);
endinterface

`default_nettype wire

[hdl/mfw_scan.sv]
// Size registers and raster position counters of the median filter.
// Depends on mfw_pkg.
`default_nettype none

module mfw_scan import mfw_pkg::*; (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_wr_en,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CFG_W-1:0]       csr_wdata,
   input  wire logic                   advance,
   output      col_type                cur_col,
   output      pos_info_type           cur_info
);

   logic [WID_W-1:0] width_ff,  width_in;
   logic [HGT_W-1:0] height_ff, height_in;
   col_type          col_ff,    col_in;
   logic [ROW_W-1:0] row_ff,    row_in;
   logic             col_last;
   logic             row_last;

   // store sizes already saturated
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_IMAGE_WIDTH: begin
               width_in = WID_W'(clamp_size(csr_wdata, 32'(MAX_WIDTH)));
            end
            CSR_IMAGE_HEIGHT: begin
               height_in = HGT_W'(clamp_size(csr_wdata, 32'(MAX_HEIGHT)));
            end
            default: begin
               width_in  = width_ff;
               height_in = height_ff;
            end
         endcase
      end
   end

   assign col_last = (32'(col_ff) + 32'd1) >= 32'(width_ff);
   assign row_last = (32'(row_ff) + 32'd1) >= 32'(height_ff);

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (advance) begin
         if (col_last) begin
            col_in = '0;
            row_in = row_last ? '0 : row_ff + ROW_W'(1);
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WID_W'(clamp_size(CFG_W'(SIZE_RESET), 32'(MAX_WIDTH)));
         height_ff <= HGT_W'(clamp_size(CFG_W'(SIZE_RESET), 32'(MAX_HEIGHT)));
         col_ff    <= '0;
         row_ff    <= '0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
      end
   end

   assign cur_col = col_ff;

   always_comb begin
      cur_info.has_result = (32'(row_ff) >= 32'(WINDOW - 1)) &&
                            (32'(col_ff) >= 32'(WINDOW - 1));
      cur_info.frame_last = row_last && col_last;
      cur_info.centre_row = COORD_W'(row_ff) - COORD_W'(HALF_WIN);
      cur_info.centre_col = COORD_W'(col_ff) - COORD_W'(HALF_WIN);
   end

endmodule

`default_nettype wire

[hdl/mfw_line_store.sv]
// Line store: one word per column holding the previous rows of that column.
// Depends on mfw_pkg.
`default_nettype none

module mfw_line_store import mfw_pkg::*; (
   input  wire logic          clock,
   input  wire logic          rd_en,
   input  wire col_type       rd_addr,
   output      line_word_type rd_data,
   input  wire logic          wr_en,
   input  wire col_type       wr_addr,
   input  wire line_word_type wr_data
);

   line_word_type mem [MAX_WIDTH];
   line_word_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // hold read data until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[hdl/mfw_median.sv]
// Rank-select median of the window: every value is ranked against all others.
// Depends on mfw_pkg.
`default_nettype none

module mfw_median import mfw_pkg::*; (
   input  wire window_type window,
   output      pixel_type  median
);

   logic [RANK_W-1:0] rank [WIN_AREA];
   logic [WIN_AREA-1:0] pick;

   // ties broken by position so ranks form a permutation
   always_comb begin
      for (int i = 0; i < WIN_AREA; i++) begin
         rank[i] = '0;
         for (int j = 0; j < WIN_AREA; j++) begin
            if (j != i) begin
               if ((window[j] < window[i]) || ((window[j] == window[i]) && (j < i))) begin
                  rank[i] = rank[i] + RANK_W'(1);
               end
            end
         end
         pick[i] = (rank[i] == RANK_W'(MEDIAN_RANK));
      end
   end

   always_comb begin
      median = '0;
      for (int i = 0; i < WIN_AREA; i++) begin
         median = median | (window[i] & {PIX_W{pick[i]}});
      end
   end

endmodule

`default_nettype wire

[hdl/median_filter_window_top.sv]
// Top level of the streaming 3x3 median filter with line stores.
// Depends on mfw_pkg, mfw_if, mfw_scan, mfw_line_store, mfw_median and the macros header.
//
// Use: pixels of one grey frame enter in raster order on req_ch, one per
// transfer. Frame width and height are set through the csr_ write port
// (index CSR_IMAGE_WIDTH / CSR_IMAGE_HEIGHT) while the block is idle; values
// outside 3 .. 1024 saturate. Each pixel whose row and column are both at
// least 2 yields one result on rsp_ch: the median of the 3x3 window centred
// one row up and one column left, with the centre's row and column, and
// frame_last on the result made by the frame's last pixel. Border pixels
// yield nothing.
// Throughput: one pixel per cycle while the receiver takes results; the line store
// takes one read at acceptance and, in the same cycle, one write of the aged column
// from the read stage. A result passes through the read stage, the window stage and
// the result register before it is presented on rsp_ch.
// Reset (synchronous, active high) empties the pipeline, clears the window,
// returns the position to row 0 column 0 and both sizes to 1024. The line
// store is not cleared; only rows already written are ever used.
// When the receiver stalls, the result is held and an interior pixel in the
// window stage waits behind it; with both stages occupied req_ch.ready drops
// in the same cycle. Border pixels in the window stage still move on.
`default_nettype none
`include "median_filter_window_top_macros.svh"

module median_filter_window_top import mfw_pkg::*; (
   input  wire logic                   clock,
   input  wire logic                   reset,
   mfw_req_if.sink                     req_ch,
   mfw_rsp_if.source                   rsp_ch,
   input  wire logic                   csr_wr_en,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CFG_W-1:0]       csr_wdata
);

   // handshake and stage movement
   logic          req_accept;
   logic          out_free;
   logic          s1_adv;
   logic          s1_free;
   logic          s2_adv;
   logic          rsp_load;

   // scan position of the pixel being accepted
   col_type       scan_col;
   pos_info_type  scan_info;

   // read stage
   logic          s1_valid_ff, s1_valid_in;
   pixel_type     s1_pixel_ff;
   col_type       s1_col_ff;
   pos_info_type  s1_info_ff;

   // window stage
   logic          s2_valid_ff, s2_valid_in;
   pos_info_type  s2_info_ff;
   window_type    window_ff, window_in;

   // line store data
   line_word_type ls_rd_data;
   line_word_type ls_wr_data;
   pixel_type     new_column [WINDOW];

   // result register
   pixel_type     median;
   logic          rsp_valid_ff, rsp_valid_in;
   pixel_type     rsp_median_ff;
   pos_info_type  rsp_info_ff;

   // ------------------------------------------------------------------
   // Flow control: each stage moves on when the one after it has room.
   // ------------------------------------------------------------------
   assign out_free   = !rsp_valid_ff || rsp_ch.ready;
   assign s2_adv     = s2_valid_ff && (!s2_info_ff.has_result || out_free);
   assign s1_adv     = s1_valid_ff && (!s2_valid_ff || s2_adv);
   assign s1_free    = !s1_valid_ff || s1_adv;
   assign req_accept = req_ch.valid && s1_free;
   assign rsp_load   = s2_adv && s2_info_ff.has_result;

   assign req_ch.ready = s1_free;

   // Position counters and size registers; advance on every transfer.
   mfw_scan u_scan (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .advance   (req_accept),
      .cur_col   (scan_col),
      .cur_info  (scan_info)
   );

   // Read the column's older rows at acceptance; write back the shifted
   // column when the pixel leaves the read stage.
   mfw_line_store u_line_store (
      .clock   (clock),
      .rd_en   (req_accept),
      .rd_addr (scan_col),
      .rd_data (ls_rd_data),
      .wr_en   (s1_adv),
      .wr_addr (s1_col_ff),
      .wr_data (ls_wr_data)
   );

   // ------------------------------------------------------------------
   // Read stage
   // ------------------------------------------------------------------
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_pixel_ff <= req_ch.pixel;
         s1_col_ff   <= scan_col;
         s1_info_ff  <= scan_info;
      end
   end

   // Push the new pixel into line 0 and age the older lines by one row.
   always_comb begin
      ls_wr_data[0] = s1_pixel_ff;
      for (int i = 1; i < LINES; i++) begin
         ls_wr_data[i] = ls_rd_data[i-1];
      end
   end

   // Column entering the window, oldest row first.
   always_comb begin
      for (int i = 0; i < LINES; i++) begin
         new_column[i] = ls_rd_data[LINES-1-i];
      end
      new_column[WINDOW-1] = s1_pixel_ff;
   end

   // ------------------------------------------------------------------
   // Window stage: shift left by one column, insert the new column.
   // ------------------------------------------------------------------
   always_comb begin
      window_in = window_ff;
      if (s1_adv) begin
         for (int i = 0; i < WINDOW; i++) begin
            for (int j = 0; j < WINDOW - 1; j++) begin
               window_in[i*WINDOW + j] = window_ff[i*WINDOW + j + 1];
            end
            window_in[i*WINDOW + WINDOW - 1] = new_column[i];
         end
      end
   end

   always_comb begin
      s2_valid_in = s2_valid_ff;
      if (s1_adv) begin
         s2_valid_in = 1'b1;
      end else if (s2_adv) begin
         s2_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         window_ff   <= '0;
      end else begin
         s2_valid_ff <= s2_valid_in;
         window_ff   <= window_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         s2_info_ff <= s1_info_ff;
      end
   end

   mfw_median u_median (
      .window (window_ff),
      .median (median)
   );

   // ------------------------------------------------------------------
   // Result register: load on an interior pixel, drop after the transfer.
   // ------------------------------------------------------------------
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_median_ff <= median;
         rsp_info_ff   <= s2_info_ff;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.median_value = rsp_median_ff;
   assign rsp_ch.centre_row   = rsp_info_ff.centre_row;
   assign rsp_ch.centre_col   = rsp_info_ff.centre_col;
   assign rsp_ch.frame_last   = rsp_info_ff.frame_last;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   `MFW_ASSERT_NOW(a_accept_into_free_stage, clock, reset, req_accept, !s1_valid_ff || s1_adv, "pixel taken while read stage is occupied")
   `MFW_ASSERT_NEXT(a_window_stage_filled, clock, reset, s1_adv, s2_valid_ff, "window stage empty after a column was shifted in")
   `MFW_ASSERT_NOW(a_no_result_overwrite, clock, reset, rsp_valid_ff && !rsp_ch.ready, !rsp_load, "waiting result overwritten")
   `MFW_ASSERT_NEXT(a_result_presented, clock, reset, rsp_load, rsp_valid_ff, "interior pixel left the window stage without a result")

endmodule

`default_nettype wire

[verif/tb_median_filter_window_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench for median_filter_window_top: streams grey frames of many sizes and
// compares each median, centre position and frame marker with a built-in window predictor.
// Depends on mfw_pkg, mfw_if and the RTL of the block; reads no files.

typedef struct packed {
   mfw_pkg::pixel_type          median_value;
   logic [mfw_pkg::COORD_W-1:0] centre_row;
   logic [mfw_pkg::COORD_W-1:0] centre_col;
   logic                        frame_last;
} median_result_type;

class median_scoreboard;

   logic [mfw_pkg::CFG_W-1:0] width_reg;
   logic [mfw_pkg::CFG_W-1:0] height_reg;
   // line 0 holds the previous row, line LINES-1 the oldest
   mfw_pkg::pixel_type line_mem [mfw_pkg::LINES][mfw_pkg::MAX_WIDTH];
   mfw_pkg::pixel_type window_px [mfw_pkg::WINDOW][mfw_pkg::WINDOW];
   int unsigned row_pos;
   int unsigned col_pos;
   median_result_type pending_medians [$];
   int unsigned mismatches;
   int unsigned medians_checked;
   int unsigned frames_closed;

   function new();
      width_reg       = mfw_pkg::CFG_W'(mfw_pkg::SIZE_RESET);
      height_reg      = mfw_pkg::CFG_W'(mfw_pkg::SIZE_RESET);
      row_pos         = 0;
      col_pos         = 0;
      mismatches      = 0;
      medians_checked = 0;
      frames_closed   = 0;
      foreach (line_mem[i, j]) line_mem[i][j] = '0;
      foreach (window_px[i, j]) window_px[i][j] = '0;
   endfunction

   function void set_size(mfw_pkg::csr_index_type idx, logic [mfw_pkg::CFG_W-1:0] value);
      case (idx)
         mfw_pkg::CSR_IMAGE_WIDTH:  width_reg  = value;
         mfw_pkg::CSR_IMAGE_HEIGHT: height_reg = value;
         default: ;
      endcase
   endfunction

   // Size in force: saturate at the build maximum, never below the window.
   function int unsigned active_size(logic [mfw_pkg::CFG_W-1:0] value, int unsigned limit);
      int unsigned v;
      v = 32'(value);
      if (v > limit) return limit;
      if (v < mfw_pkg::WINDOW) return mfw_pkg::WINDOW;
      return v;
   endfunction

   function int unsigned frame_pixels();
      return active_size(width_reg, mfw_pkg::MAX_WIDTH) *
             active_size(height_reg, mfw_pkg::MAX_HEIGHT);
   endfunction

   function bit at_frame_start();
      return row_pos == 0 && col_pos == 0;
   endfunction

   function int unsigned pending();
      return pending_medians.size();
   endfunction

   // Rank test: v is the median when at most MEDIAN_RANK values lie below it
   // and more than MEDIAN_RANK lie at or below it.
   function mfw_pkg::pixel_type window_median();
      mfw_pkg::pixel_type flat [mfw_pkg::WIN_AREA];
      int unsigned below;
      int unsigned not_above;
      mfw_pkg::pixel_type found;
      found = '0;
      foreach (window_px[i, j]) flat[i * mfw_pkg::WINDOW + j] = window_px[i][j];
      for (int k = 0; k < mfw_pkg::WIN_AREA; k++) begin
         below     = 0;
         not_above = 0;
         for (int i = 0; i < mfw_pkg::WIN_AREA; i++) begin
            if (flat[i] < flat[k]) below++;
            if (flat[i] <= flat[k]) not_above++;
         end
         if (below <= mfw_pkg::MEDIAN_RANK && not_above > mfw_pkg::MEDIAN_RANK) found = flat[k];
      end
      return found;
   endfunction

   function void note_pixel(mfw_pkg::pixel_type px);
      mfw_pkg::pixel_type column [mfw_pkg::WINDOW];
      int unsigned w;
      int unsigned h;
      int unsigned c;
      int unsigned r;
      median_result_type res;
      w = active_size(width_reg, mfw_pkg::MAX_WIDTH);
      h = active_size(height_reg, mfw_pkg::MAX_HEIGHT);
      c = col_pos % mfw_pkg::MAX_WIDTH;
      r = row_pos;
      for (int i = 0; i < mfw_pkg::LINES; i++) column[i] = line_mem[mfw_pkg::LINES - 1 - i][c];
      column[mfw_pkg::WINDOW - 1] = px;
      for (int i = mfw_pkg::LINES - 1; i > 0; i--) line_mem[i][c] = line_mem[i - 1][c];
      line_mem[0][c] = px;
      for (int i = 0; i < mfw_pkg::WINDOW; i++) begin
         for (int j = 0; j < mfw_pkg::WINDOW - 1; j++) window_px[i][j] = window_px[i][j + 1];
         window_px[i][mfw_pkg::WINDOW - 1] = column[i];
      end
      if (r >= mfw_pkg::WINDOW - 1 && c >= mfw_pkg::WINDOW - 1) begin
         res.median_value = window_median();
         res.centre_row   = mfw_pkg::COORD_W'(r - mfw_pkg::HALF_WIN);
         res.centre_col   = mfw_pkg::COORD_W'(c - mfw_pkg::HALF_WIN);
         res.frame_last   = (r + 1 >= h) && (c + 1 >= w);
         pending_medians.push_back(res);
      end
      if (c + 1 >= w) begin
         col_pos = 0;
         row_pos = (r + 1 >= h) ? 0 : r + 1;
      end else begin
         col_pos = c + 1;
      end
   endfunction

   function void compare_field(string field, logic [15:0] want_v, logic [15:0] got_v);
      if (got_v !== want_v) begin
         $error("%s: expected %0d, got %0d", field, want_v, got_v);
         mismatches++;
      end
   endfunction

   function void check_result(median_result_type got);
      median_result_type want;
      if (pending_medians.size() == 0) begin
         $error("result with none outstanding: median %0d row %0d col %0d",
                got.median_value, got.centre_row, got.centre_col);
         mismatches++;
         return;
      end
      want = pending_medians.pop_front();
      medians_checked++;
      if (want.frame_last) frames_closed++;
      compare_field("median_value", 16'(want.median_value), 16'(got.median_value));
      compare_field("centre_row", 16'(want.centre_row), 16'(got.centre_row));
      compare_field("centre_col", 16'(want.centre_col), 16'(got.centre_col));
      compare_field("frame_last", 16'(want.frame_last), 16'(got.frame_last));
   endfunction

endclass

module tb_median_filter_window_top;
   import mfw_pkg::*;

   localparam int CLOCK_PERIOD  = 20;
   localparam int RESET_CYCLES  = 6;
   localparam int RANDOM_PIXELS = 780;
   // Margin for the pipeline to drain; pixels on borders leave no result to wait for.
   localparam int SETTLE_CYCLES = 6;
   localparam int CYCLE_LIMIT   = 600000;

   typedef enum {
      TEXTURE_NOISE,
      TEXTURE_EXTREMES,
      TEXTURE_BAND,
      TEXTURE_SPECKLE
   } texture_kind_type;

   logic                   clock;
   logic                   reset;
   logic                   csr_wr_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CFG_W-1:0]       csr_wdata;

   mfw_req_if req_bus ();
   mfw_rsp_if rsp_bus ();

   median_scoreboard medians = new();

   // Set for a phase to run both sides of the block without idling.
   bit          steady;
   int unsigned pixels_sent;
   int unsigned random_pixels;
   int unsigned mid_frame_changes;
   int unsigned cycle_count;

   // Opening frame, 3x3: both extremes, mid-scale and alternating bit patterns.
   pixel_type corner_pixels [9] = '{8'h00, 8'hFF, 8'h80, 8'h7F, 8'h01,
                                    8'hFE, 8'h55, 8'hAA, 8'hFF};
   // 4x4 frame with flat areas, ties and isolated impulses.
   pixel_type impulse_pixels [16] = '{8'h10, 8'h10, 8'h10, 8'h10,
                                      8'h10, 8'hFF, 8'h10, 8'h00,
                                      8'h00, 8'h00, 8'hFF, 8'hFF,
                                      8'hFF, 8'h10, 8'h00, 8'h10};

   median_filter_window_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_bus),
      .rsp_ch    (rsp_bus),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // Abort a run that hangs: a lost result or a stuck handshake ends here.
   initial begin : watchdog
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Simulation FAILED");
      $finish;
   end

   // Check every result transfer against the oldest outstanding median.
   always @(posedge clock) begin : result_monitor
      median_result_type seen;
      if (reset === 1'b0 && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         seen.median_value = rsp_bus.median_value;
         seen.centre_row   = rsp_bus.centre_row;
         seen.centre_col   = rsp_bus.centre_col;
         seen.frame_last   = rsp_bus.frame_last;
         medians.check_result(seen);
      end
   end

   // Receiver: before each result ready may be held low, at random and never in steady
   // phases; then it stays high until a transfer happens. Every change lands on a falling edge.
   initial begin : result_ready_driver
      int unsigned hold;
      rsp_bus.ready = 1'b0;
      @(negedge clock);
      while (reset !== 1'b0) @(negedge clock);
      forever begin
         hold = steady ? 0 : $urandom_range(0, 4);
         if (hold > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (hold) @(negedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (rsp_bus.valid !== 1'b1);
         @(negedge clock);
      end
   end

   function automatic pixel_type draw_pixel(texture_kind_type kind, pixel_type base);
      pixel_type px;
      case (kind)
         TEXTURE_EXTREMES: px = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
         TEXTURE_BAND:     px = PIX_W'(base + $urandom_range(0, 6));
         TEXTURE_SPECKLE: begin
            if ($urandom_range(0, 7) == 0) begin
               px = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
            end else begin
               px = base;
            end
         end
         default:          px = PIX_W'($urandom_range(0, 255));
      endcase
      return px;
   endfunction

   // Called and returning on a falling edge. Unless steady, may first drop valid at random;
   // then hold valid with the pixel until the transfer; valid stays high on return so a
   // back-to-back pixel needs no second assignment in the same step.
   task automatic send_pixel(input pixel_type px);
      int unsigned gap;
      gap = steady ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.pixel <= px;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      medians.note_pixel(px);
      pixels_sent++;
      @(negedge clock);
   endtask

   task automatic send_pixels(input int unsigned count, input texture_kind_type kind,
                              input pixel_type base);
      repeat (count) send_pixel(draw_pixel(kind, base));
   endtask

   // Feed pixels until the block's position returns to the top left corner.
   task automatic finish_frame(input texture_kind_type kind, input pixel_type base);
      while (!medians.at_frame_start()) send_pixel(draw_pixel(kind, base));
   endtask

   // Drop valid, wait for every outstanding median, then let the pipeline
   // settle: the last pixels may have been border pixels still in flight.
   task automatic wait_quiet();
      req_bus.valid <= 1'b0;
      while (medians.pending() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Write width then height as back-to-back writes; only ever called idle.
   task automatic write_sizes(input logic [CFG_W-1:0] width_value,
                              input logic [CFG_W-1:0] height_value);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_IMAGE_WIDTH;
      csr_wdata <= width_value;
      medians.set_size(CSR_IMAGE_WIDTH, width_value);
      @(negedge clock);
      csr_index <= CSR_IMAGE_HEIGHT;
      csr_wdata <= height_value;
      medians.set_size(CSR_IMAGE_HEIGHT, height_value);
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // One random phase: mostly small whole frames, some with sizes below the
   // window, and now and then a resize part way through a frame followed by
   // enough pixels to bring the position back to the corner.
   task automatic run_random_phase();
      texture_kind_type kind;
      pixel_type        base;
      int unsigned      start_count;
      int unsigned      w_val;
      int unsigned      h_val;
      int unsigned      part;
      start_count = pixels_sent;
      steady      = ($urandom_range(0, 3) == 0);
      kind        = texture_kind_type'($urandom_range(0, 3));
      base        = PIX_W'($urandom_range(0, 255));
      w_val       = ($urandom_range(0, 4) == 0) ? $urandom_range(13, 64) : $urandom_range(3, 12);
      h_val       = $urandom_range(3, 8);
      if ($urandom_range(0, 7) == 0) w_val = $urandom_range(0, 2);
      if ($urandom_range(0, 7) == 0) h_val = $urandom_range(0, 2);
      write_sizes(CFG_W'(w_val), CFG_W'(h_val));
      if ($urandom_range(0, 4) == 0) begin
         part = $urandom_range(1, medians.frame_pixels() - 1);
         send_pixels(part, kind, base);
         wait_quiet();
         // New size may leave the counters at or past the new last position.
         write_sizes(CFG_W'($urandom_range(0, 16)), CFG_W'($urandom_range(0, 8)));
         mid_frame_changes++;
         finish_frame(kind, base);
      end else begin
         send_pixels(medians.frame_pixels(), kind, base);
      end
      wait_quiet();
      random_pixels += pixels_sent - start_count;
   endtask

   initial begin : stimulus
      reset             = 1'b1;
      csr_wr_en         = 1'b0;
      csr_index         = CSR_IMAGE_WIDTH;
      csr_wdata         = '0;
      req_bus.valid     = 1'b0;
      req_bus.pixel     = '0;
      steady            = 1'b0;
      pixels_sent       = 0;
      random_pixels     = 0;
      mid_frame_changes = 0;

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Smallest frame, both sizes written below the window so they round up.
      write_sizes(0, 2);
      foreach (corner_pixels[i]) send_pixel(corner_pixels[i]);
      wait_quiet();

      // 4x4: four interior results, ties and impulses in the windows.
      write_sizes(4, 4);
      foreach (impulse_pixels[i]) send_pixel(impulse_pixels[i]);
      wait_quiet();

      // Oversized width: the first row wraps after the maximum width. The rest
      // of the frame runs 16 wide, which refreshes both lines of the first 16
      // columns so later resizes only pull in written data.
      write_sizes(11'd1500, 3);
      send_pixels(MAX_WIDTH, TEXTURE_NOISE, 8'h00);
      wait_quiet();
      write_sizes(16, 3);
      mid_frame_changes++;
      finish_frame(TEXTURE_NOISE, 8'h00);
      wait_quiet();

      // Oversized height cut short: after twelve rows the height drops to 3,
      // so the row counter is past the new last row and wraps at the row end.
      write_sizes(3, 11'h7FF);
      send_pixels(36, TEXTURE_BAND, 8'hF8);
      wait_quiet();
      write_sizes(3, 3);
      mid_frame_changes++;
      finish_frame(TEXTURE_SPECKLE, 8'h40);
      wait_quiet();

      while (random_pixels < RANDOM_PIXELS) run_random_phase();

      steady = 1'b0;
      wait_quiet();
      $display("Streamed %0d pixels; checked %0d medians across %0d closed frames.",
               pixels_sent, medians.medians_checked, medians.frames_closed);
      $display("Sizes ran from the 3x3 minimum to a saturated 1024-pixel row, %0d resized mid-frame.",
               mid_frame_changes);
      if (medians.mismatches == 0 && medians.pending() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

[sim.f]
+incdir+hdl
hdl/mfw_pkg.sv
hdl/mfw_if.sv
hdl/mfw_scan.sv
hdl/mfw_line_store.sv
hdl/mfw_median.sv
hdl/median_filter_window_top.sv
verif/tb_median_filter_window_top.sv
